/* design/alurf_pkg.sv */
`default_nettype none

package alurf_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned REG_AW = 3;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned IMM_W = 8;
    localparam int unsigned SHAMT_W = 4;

    // Instruction mode field, bits 1:0.
    typedef enum logic [1:0] {
        MODE_REG    = 2'd0,
        MODE_IMM    = 2'd1,
        MODE_BRANCH = 2'd2,
        MODE_REG_ALT = 2'd3
    } t_mode;

    // ALU select field, bits 4:2.
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_AND = 3'd2,
        ALU_OR  = 3'd3,
        ALU_XOR = 3'd4,
        ALU_SHL = 3'd5,
        ALU_SHR = 3'd6,
        ALU_CMP = 3'd7
    } t_alu_op;

    // Branch condition, bits 3:2 in branch mode.
    typedef enum logic [1:0] {
        BR_ZERO = 2'd0,
        BR_POS  = 2'd1,
        BR_NEG  = 2'd2,
        BR_NONE = 2'd3
    } t_br_cond;

    // Compare results written by the compare operation.
    localparam logic [DATA_W-1:0] CMP_EQ = 16'd0;
    localparam logic [DATA_W-1:0] CMP_GT = 16'd1;
    localparam logic [DATA_W-1:0] CMP_LT = 16'd2;

    localparam logic [DATA_W-1:0] PC_RESET = 16'h0000;

    // Value that each register holds after reset.
    function automatic logic [DATA_W-1:0] reg_reset_value(input logic [REG_AW-1:0] idx);
        logic [DATA_W-1:0] v;
        case (idx)
            3'd0: v = 16'hE013;
            3'd1: v = 16'h1234;
            3'd2: v = 16'hF79A;
            3'd3: v = 16'h8012;
            3'd4: v = 16'h6345;
            3'd5: v = 16'hABCD;
            3'd6: v = 16'h7B23;
            3'd7: v = 16'hABBB;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* design/alu_register_file_execute_top.sv */
// Path: an accepted item is held in stage one and moves into the result register
// when that register is empty or being drained. Throughput: one item per cycle
// while the output is not stalled; the operand read and the register write of the
// previous item overlap, with a write-to-read bypass on the register file.
// Reset (synchronous, active low): the registers return to their fixed start
// values, the program counter to zero, and both pipeline stages are emptied.
`default_nettype none

module alu_register_file_execute_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel: one instruction word per item.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_instruction,
    // Output channel: one result item per instruction.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_result,
    output logic [15:0]      o_program_counter,
    output logic             o_branch_taken
);

    // ------------------------------------------------------------------
    // Stage one holds the accepted instruction together with the two
    // operands read from the register file at acceptance. Stage two is
    // the result register. The register file is written when a non-branch
    // item moves from stage one to stage two ("fire"), so the next item, read
    // at that same edge, takes the new value through the bypass.
    // ------------------------------------------------------------------

    logic                                    r_in_valid;
    logic [15:0]                             r_ins;
    logic [alurf_pkg::DATA_W-1:0]            r_opa;
    logic [alurf_pkg::DATA_W-1:0]            r_opb;

    logic [alurf_pkg::DATA_W-1:0]            r_bank [alurf_pkg::NUM_REGS];
    logic [alurf_pkg::NUM_REGS-1:0]          r_bank_vld;
    logic [alurf_pkg::DATA_W-1:0]            r_r0;
    logic [alurf_pkg::DATA_W-1:0]            r_pc;

    logic                                    r_out_valid;
    logic [alurf_pkg::DATA_W-1:0]            r_result;
    logic [alurf_pkg::DATA_W-1:0]            r_out_pc;
    logic                                    r_out_taken;

    logic                                    fire;
    logic                                    accept;

    // Fields of the instruction in stage one.
    logic [alurf_pkg::REG_AW-1:0]            rx;
    logic [alurf_pkg::IMM_W-1:0]             imm;
    alurf_pkg::t_alu_op                      alu_op;
    alurf_pkg::t_mode                        mode;
    alurf_pkg::t_br_cond                     br_cond;
    logic                                    is_branch;

    // Read addresses of the incoming instruction.
    logic [alurf_pkg::REG_AW-1:0]            in_rx;
    logic [alurf_pkg::REG_AW-1:0]            in_ry;

    logic [alurf_pkg::DATA_W-1:0]            src;
    logic [alurf_pkg::DATA_W-1:0]            alu_out;
    logic                                    taken;
    logic                                    wr_en;
    logic [alurf_pkg::DATA_W-1:0]            rd_x;
    logic [alurf_pkg::DATA_W-1:0]            rd_y;
    logic [alurf_pkg::DATA_W-1:0]            n_pc;

    // Handshake: stage one moves on when the result register is empty or
    // being drained; a new item enters whenever stage one empties.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign accept     = i_in_valid && o_in_ready;

    assign rx        = r_ins[15:13];
    assign imm       = r_ins[12:5];
    assign alu_op    = alurf_pkg::t_alu_op'(r_ins[4:2]);
    assign mode      = alurf_pkg::t_mode'(r_ins[1:0]);
    assign br_cond   = alurf_pkg::t_br_cond'(r_ins[3:2]);
    assign is_branch = (mode == alurf_pkg::MODE_BRANCH);

    assign in_rx = i_instruction[15:13];
    assign in_ry = i_instruction[12:10];

    // Immediate mode takes the zero-extended immediate in place of ry.
    assign src = (mode == alurf_pkg::MODE_IMM)
               ? {{(alurf_pkg::DATA_W-alurf_pkg::IMM_W){1'b0}}, imm} : r_opb;

    always_comb begin
        case (alu_op)
            alurf_pkg::ALU_ADD: alu_out = r_opa + src;
            alurf_pkg::ALU_SUB: alu_out = r_opa - src;
            alurf_pkg::ALU_AND: alu_out = r_opa & src;
            alurf_pkg::ALU_OR:  alu_out = r_opa | src;
            alurf_pkg::ALU_XOR: alu_out = r_opa ^ src;
            alurf_pkg::ALU_SHL: alu_out = r_opa << src[alurf_pkg::SHAMT_W-1:0];
            alurf_pkg::ALU_SHR: alu_out = r_opa >> src[alurf_pkg::SHAMT_W-1:0];
            alurf_pkg::ALU_CMP: begin
                if (r_opa == src) begin
                    alu_out = alurf_pkg::CMP_EQ;
                end else if (r_opa > src) begin
                    alu_out = alurf_pkg::CMP_GT;
                end else begin
                    alu_out = alurf_pkg::CMP_LT;
                end
            end
            default: alu_out = r_opa;
        endcase
    end

    // Register 0 is tested as a signed value. It is kept in a shadow copy
    // so the branch test never needs a third read port on the file.
    always_comb begin
        taken = 1'b0;
        if (is_branch) begin
            case (br_cond)
                alurf_pkg::BR_ZERO: taken = (r_r0 == '0);
                alurf_pkg::BR_POS:  taken = !r_r0[alurf_pkg::DATA_W-1] && (r_r0 != '0);
                alurf_pkg::BR_NEG:  taken = r_r0[alurf_pkg::DATA_W-1];
                alurf_pkg::BR_NONE: taken = 1'b0;
                default:            taken = 1'b0;
            endcase
        end
    end

    assign wr_en = fire && !is_branch;
    assign n_pc  = taken ? {{(alurf_pkg::DATA_W-alurf_pkg::IMM_W){1'b0}}, imm} : r_pc;

    // Register file read with write bypass. An entry that was never written
    // since reset reads as its start value.
    always_comb begin
        if (wr_en && (rx == in_rx)) begin
            rd_x = alu_out;
        end else if (r_bank_vld[in_rx]) begin
            rd_x = r_bank[in_rx];
        end else begin
            rd_x = alurf_pkg::reg_reset_value(in_rx);
        end
        if (wr_en && (rx == in_ry)) begin
            rd_y = alu_out;
        end else if (r_bank_vld[in_ry]) begin
            rd_y = r_bank[in_ry];
        end else begin
            rd_y = alurf_pkg::reg_reset_value(in_ry);
        end
    end

    // Register file storage and its read registers.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bank[rx] <= alu_out;
        end
        if (accept) begin
            r_ins <= i_instruction;
            r_opa <= rd_x;
            r_opb <= rd_y;
        end
    end

    // Control state, the shadow of register 0 and the program counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_bank_vld <= '0;
            r_r0       <= alurf_pkg::reg_reset_value('0);
            r_pc       <= alurf_pkg::PC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (wr_en) begin
                r_bank_vld[rx] <= 1'b1;
                if (rx == '0) begin
                    r_r0 <= alu_out;
                end
            end
            if (fire) begin
                r_pc <= n_pc;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register payload. A branch reports rx as it was.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result    <= is_branch ? r_opa : alu_out;
            r_out_pc    <= n_pc;
            r_out_taken <= taken;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result          = r_result;
    assign o_program_counter = r_out_pc;
    assign o_branch_taken    = r_out_taken;

    // An empty instruction stage always takes a new item.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stage empty but not ready");

    // The program counter moves only on a taken branch.
    a_pc_only_on_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fire && taken) |=> $stable(r_pc))
        else $error("program counter changed without a taken branch");

    // Every item that leaves stage one lands in the result register.
    a_fire_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("executed item did not reach the result register");

    // A branch leaves the destination register value untouched.
    a_branch_keeps_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_branch) |=> (o_result == $past(r_opa)))
        else $error("branch altered the reported register value");

endmodule

`default_nettype wire
